// ===== rtl/dvrc_pkg.sv =====
// Shared types and constants for the distance-vector route coordinator.
// No dependencies; imported by every module of the block.
package dvrc_pkg;

  localparam int NODES_DEF = 64;        // default routing table depth
  localparam int NBR       = 8;         // neighbour slots, one per send_mask bit
  localparam int IDW       = 6;         // node id width
  localparam int DW        = 8;         // distance width
  localparam int AWW       = 1 << IDW;  // awaiting-reply bitmap, one bit per node id
  localparam int MSGS      = 3;         // most messages one table entry can cause

  localparam logic [DW-1:0] DIST_INF = 8'hFF;
  localparam logic [6:0]    NONE_ID  = 7'd127;

  // operation codes
  localparam logic [2:0] OP_ROUTE   = 3'd0;
  localparam logic [2:0] OP_COORD   = 3'd1;
  localparam logic [2:0] OP_UNCOORD = 3'd2;
  localparam logic [2:0] OP_LINK    = 3'd3;
  localparam logic [2:0] OP_SET     = 3'd4;

  // message kinds
  localparam logic [1:0] KIND_ROUTE   = 2'd0;
  localparam logic [1:0] KIND_COORD   = 2'd1;
  localparam logic [1:0] KIND_UNCOORD = 2'd2;

  typedef struct packed {
    logic [2:0]     operation;
    logic [2:0]     slot;
    logic [IDW-1:0] destination;
    logic [DW-1:0]  distance;
    logic [IDW-1:0] neighbour_node;
    logic           neighbour_present;
  } in_word_t;

  typedef struct packed {
    logic [1:0]     message_kind;
    logic [IDW-1:0] message_destination;
    logic [DW-1:0]  message_distance;
    logic [NBR-1:0] send_mask;
    logic           last;
  } out_word_t;

  typedef struct packed {
    logic [DW-1:0]  metric;
    logic [6:0]     nh;
    logic           coord;
    logic [6:0]     init;
    logic [AWW-1:0] aw;
  } entry_t;

  localparam entry_t ENTRY_RST = '{metric: DIST_INF, nh: NONE_ID, coord: 1'b0,
                                   init: NONE_ID, aw: '0};

  typedef struct packed {
    logic           v;
    logic [1:0]     kind;
    logic [DW-1:0]  metric;
    logic [NBR-1:0] mask;
  } msg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_READ, ST_CALC, ST_EMIT, ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic slot_wr;
    logic idx_first;
    logic idx_inc;
    logic rd_en;
    logic calc;
    logic take;
    logic skip;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sender_ok;
    logic       dest_ok;
    logic       msg_v;
    logic       ptr_end;
    logic       held_v;
    logic       out_free;
    logic       idx_end;
  } ctl_sts_t;

endpackage

// ===== rtl/dvrc_dp.sv =====
// Datapath: input word, neighbour slots, routing table memory, entry update,
// message buffer and output register. Depends on dvrc_pkg.
module dvrc_dp import dvrc_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  ctl_cmd_t  cmd,
  output ctl_sts_t  sts,
  input  logic      out_stall,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  typedef struct packed {
    entry_t          e;
    msg_t [MSGS-1:0] m;
  } res_t;

  in_word_t                 in_r;
  logic [NBR-1:0][IDW-1:0]  slot_node_r;
  logic [NBR-1:0]           slot_pres_r;
  logic [AW-1:0]            idx_r;
  entry_t                   mem [NODES];
  logic [NODES-1:0]         vld_r;
  entry_t                   rd_r;
  logic                     rd_vld_r;
  msg_t [MSGS-1:0]          msgs_r;
  logic [1:0]               ptr_r;
  out_word_t                held_r;
  logic                     held_v_r;
  logic                     out_v_r;
  out_word_t                out_r;

  entry_t         cur;
  res_t           res;
  logic [IDW-1:0] j;
  logic [NBR-1:0] sbit;

  function automatic msg_t mk(logic [1:0] kind, logic [DW-1:0] metric, logic [NBR-1:0] mask);
    msg_t m;
    m.v      = (mask != '0);
    m.kind   = kind;
    m.metric = metric;
    m.mask   = mask;
    return m;
  endfunction

  // leave coordination once no present neighbour owes a reply
  function automatic res_t end_check(entry_t e, logic [NBR-1:0] pres,
                                     logic [NBR-1:0][IDW-1:0] sn);
    res_t           r;
    logic           pend;
    logic           found;
    logic [NBR-1:0] rmask;
    logic [NBR-1:0] umask;
    r.e   = e;
    r.m   = '0;
    pend  = 1'b0;
    found = 1'b0;
    rmask = '0;
    umask = '0;
    for (int k = 0; k < NBR; k++) begin
      if (pres[k] && e.aw[sn[k]]) pend = 1'b1;
      if (pres[k] && {1'b0, sn[k]} != e.nh) rmask[k] = 1'b1;
      if (!found && pres[k] && {1'b0, sn[k]} == e.init) begin
        umask[k] = 1'b1;
        found    = 1'b1;
      end
    end
    if (e.coord && !pend) begin
      r.e.coord = 1'b0;
      if (e.metric != DIST_INF) r.m[0] = mk(KIND_ROUTE, e.metric, rmask);
      if (e.init != NONE_ID) begin
        r.m[1]   = mk(KIND_UNCOORD, '0, umask);
        r.e.init = NONE_ID;
      end
    end
    return r;
  endfunction

  function automatic res_t start_coord(entry_t e, logic [6:0] init, logic [NBR-1:0] skip,
                                       logic [NBR-1:0] pres, logic [NBR-1:0][IDW-1:0] sn);
    res_t           r;
    res_t           ec;
    entry_t         t;
    logic [NBR-1:0] mask;
    t        = e;
    t.coord  = 1'b1;
    t.init   = init;
    t.metric = DIST_INF;
    t.nh     = NONE_ID;
    mask     = pres & ~skip;
    for (int k = 0; k < NBR; k++) begin
      if (mask[k]) t.aw[sn[k]] = 1'b1;
    end
    ec     = end_check(t, pres, sn);
    r.e    = ec.e;
    r.m[0] = mk(KIND_COORD, '0, mask);
    r.m[1] = ec.m[0];
    r.m[2] = ec.m[1];
    return r;
  endfunction

  assign j    = slot_node_r[in_r.slot];
  assign sbit = NBR'(1) << in_r.slot;
  assign cur  = rd_vld_r ? rd_r : ENTRY_RST;

  always_comb begin
    res   = '0;
    res.e = cur;
    case (in_r.operation)
      OP_ROUTE: begin
        if ({1'b0, in_r.distance} + 9'd1 < {1'b0, cur.metric}) begin
          res.e.metric = in_r.distance + 8'd1;
          res.e.nh     = {1'b0, j};
          if (!cur.coord)
            res.m[0] = mk(KIND_ROUTE, in_r.distance + 8'd1, slot_pres_r & ~sbit);
        end
      end
      OP_COORD: begin
        if (cur.coord) begin
          res = '0;
          res.e = cur;
          if (cur.nh == {1'b0, j}) begin
            res.e.metric = DIST_INF;
            res.e.nh     = NONE_ID;
          end
          res = end_check(res.e, slot_pres_r, slot_node_r);
          res.m[2] = res.m[1];
          res.m[1] = res.m[0];
          res.m[0] = mk(KIND_UNCOORD, '0, sbit);
        end else if (cur.nh != {1'b0, j}) begin
          res.m[0] = mk(KIND_ROUTE, cur.metric, sbit);
          res.m[1] = mk(KIND_UNCOORD, '0, sbit);
        end else begin
          res = start_coord(cur, {1'b0, j}, '0, slot_pres_r, slot_node_r);
        end
      end
      OP_UNCOORD: begin
        if (cur.coord) begin
          res.e.aw[j] = 1'b0;
          res = end_check(res.e, slot_pres_r, slot_node_r);
          // still coordinating: the sender may be our successor
          if (res.e.coord && res.e.nh == {1'b0, j}) begin
            res.e.init   = {1'b0, j};
            res.e.metric = DIST_INF;
            res.e.nh     = NONE_ID;
          end
        end
      end
      OP_LINK: begin
        if (cur.nh == {1'b0, j})
          res = start_coord(cur, NONE_ID, sbit, slot_pres_r, slot_node_r);
        else
          res.e.aw[j] = 1'b0;
      end
      default: res = '0;
    endcase
  end

  // input word and neighbour slots
  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_node_r <= '0;
      slot_pres_r <= '0;
    end else if (cmd.slot_wr) begin
      slot_node_r[in_r.slot] <= in_r.neighbour_node;
      slot_pres_r[in_r.slot] <= in_r.neighbour_present;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_first)
      idx_r <= (in_r.operation == OP_LINK) ? '0 : in_r.destination[AW-1:0];
    else if (cmd.idx_inc)
      idx_r <= idx_r + AW'(1);
  end

  // table memory, one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.calc) mem[idx_r] <= res.e;
    if (cmd.rd_en) rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.calc) vld_r[idx_r] <= 1'b1;
      if (cmd.rd_en) rd_vld_r <= vld_r[idx_r];
    end
  end

  // message buffer for the current entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.calc) begin
      ptr_r <= '0;
    end else if (cmd.take || cmd.skip) begin
      ptr_r <= ptr_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) msgs_r <= res.m;
  end

  // one-deep hold so the final word of an input can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) held_v_r <= 1'b0;
    else if (cmd.take) held_v_r <= 1'b1;
    else if (cmd.flush) held_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.take)
      held_r <= '{message_kind: msgs_r[ptr_r].kind,
                  message_destination: IDW'(idx_r),
                  message_distance: msgs_r[ptr_r].metric,
                  send_mask: msgs_r[ptr_r].mask,
                  last: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if ((cmd.take && held_v_r) || cmd.flush) out_v_r <= 1'b1;
    else if (!out_stall) out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if ((cmd.take && held_v_r) || cmd.flush)
      out_r <= '{message_kind: held_r.message_kind,
                 message_destination: held_r.message_destination,
                 message_distance: held_r.message_distance,
                 send_mask: held_r.send_mask,
                 last: cmd.flush};
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

  always_comb begin
    sts           = '0;
    sts.op        = in_r.operation;
    sts.sender_ok = slot_pres_r[in_r.slot];
    sts.dest_ok   = ({1'b0, in_r.destination} < 7'(NODES));
    sts.msg_v     = msgs_r[ptr_r].v;
    sts.ptr_end   = (ptr_r == 2'(MSGS - 1));
    sts.held_v    = held_v_r;
    sts.out_free  = !out_v_r || !out_stall;
    sts.idx_end   = (idx_r == AW'(NODES - 1));
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.take && held_v_r) || cmd.flush) |-> (!out_v_r || !out_stall))
    else $error("output register overwritten while stalled");
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take || cmd.skip) |-> (ptr_r <= 2'(MSGS - 1)))
    else $error("message pointer past buffer");
  a_flush_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> !held_v_r && out_v_r && out_r.last)
    else $error("flush did not send the held word as last");

endmodule

// ===== rtl/dvrc_ctrl.sv =====
// Controller: sequences decode, table read, update and message emission.
// Depends on dvrc_pkg.
module dvrc_ctrl import dvrc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   msg_op;
  logic   go_on;

  assign msg_op = (sts.op == OP_ROUTE) || (sts.op == OP_COORD) || (sts.op == OP_UNCOORD);
  // current message can be consumed this cycle
  assign go_on  = !sts.msg_v || !sts.held_v || sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        if (sts.sender_ok && ((msg_op && sts.dest_ok) || sts.op == OP_LINK))
          state_nxt = ST_READ;
        else
          state_nxt = ST_IDLE;
      end
      ST_READ:   state_nxt = ST_CALC;
      ST_CALC:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (go_on && sts.ptr_end) begin
          if (sts.op == OP_LINK && !sts.idx_end) state_nxt = ST_READ;
          else state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH:  if (!sts.held_v || sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:   cmd.load_in = in_valid;
      ST_DECODE: begin
        cmd.slot_wr   = (sts.op == OP_SET);
        cmd.idx_first = sts.sender_ok && ((msg_op && sts.dest_ok) || sts.op == OP_LINK);
      end
      ST_READ:   cmd.rd_en = 1'b1;
      ST_CALC:   cmd.calc  = 1'b1;
      ST_EMIT: begin
        cmd.take    = sts.msg_v && go_on;
        cmd.skip    = !sts.msg_v;
        cmd.idx_inc = go_on && sts.ptr_end && sts.op == OP_LINK && !sts.idx_end;
      end
      ST_FLUSH:  cmd.flush = sts.held_v && sts.out_free;
      default:   cmd = '0;
    endcase
  end

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take && cmd.skip))
    else $error("take and skip together");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_DECODE)
    else $error("accepted word not decoded");
  a_calc_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |-> $past(cmd.rd_en))
    else $error("update without a table read");

endmodule

// ===== rtl/distance_vector_route_coordinator.sv =====
// Top level of the distance-vector route coordinator.
// Instantiates dvrc_ctrl and dvrc_dp; depends on dvrc_pkg.
//
//   channel | ports                         | payload
//   --------+-------------------------------+------------------------------
//   in      | in_valid, in_stall, in_word   | in_word_t  (operation..present)
//   out     | out_valid, out_stall, out_word| out_word_t (kind..last)
//
// One word at a time. A set-slot or an ignored word is accepted and decoded only.
// A message word passes decode, a registered table read, the update, three
// message slots through the emit stage, the flush and the return to idle.
// A link-down walks every destination in turn through read, update and emit,
// using the table's one read and one write port.
// Reset is synchronous active low; the table reads as unreachable through
// per-entry valid bits, so no clearing pass is needed.
// out_stall holds the emit and flush stages only while the held word cannot move on.
module distance_vector_route_coordinator import dvrc_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer: one table entry per pass through read/calc/emit
  dvrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, slots and message path
  dvrc_dp #(.NODES(NODES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
